>>> sv/matrix_keypad_scanner_defines.svh
// Assertion macros shared by the keypad scanner RTL.
`ifndef MATRIX_KEYPAD_SCANNER_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MKS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad scanner assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad scanner assertion failed");

`endif

>>> sv/mks_pkg.sv
// Types, constants and lookup functions for the keypad scanner.
package mks_pkg;

    localparam logic [3:0]  ROWS_IDLE     = 4'hF;
    localparam logic [3:0]  DRIVE_IDLE    = 4'hF;
    localparam logic [3:0]  DRIVE_ALL     = 4'h0;
    localparam logic [15:0] SETTLE_RESET  = 16'd50;

    typedef enum logic [1:0] {
        PH_SETTLE_PRE  = 2'd0,
        PH_RELEASE     = 2'd1,
        PH_SETTLE_POST = 2'd2,
        PH_SCAN        = 2'd3
    } phase_t;

    typedef struct packed {
        logic [3:0] col_drive;
        logic       key_valid;
        logic [4:0] key_index;
        logic [6:0] legend_char;
    } key_word_t;

    function automatic logic [3:0] column_drive(input logic [1:0] col);
        return ~(4'b0001 << col);
    endfunction

    // Highest active-low row wins; 0 when no row is low.
    function automatic logic [2:0] row_code(input logic [3:0] rows);
        logic [3:0] act;
        act = ~rows;
        priority if (act[3]) return 3'd4;
        else if (act[2]) return 3'd3;
        else if (act[1]) return 3'd2;
        else if (act[0]) return 3'd1;
        else return 3'd0;
    endfunction

    // Key 1 is the clear command and carries no character.
    function automatic logic [6:0] legend_of(input logic [4:0] key);
        logic [6:0] ch;
        unique case (key)
            5'd2:    ch = 7'h31; // '1'
            5'd3:    ch = 7'h34; // '4'
            5'd4:    ch = 7'h37; // '7'
            5'd5:    ch = 7'h30; // '0'
            5'd6:    ch = 7'h32; // '2'
            5'd7:    ch = 7'h35; // '5'
            5'd8:    ch = 7'h38; // '8'
            5'd9:    ch = 7'h3D; // '='
            5'd10:   ch = 7'h33; // '3'
            5'd11:   ch = 7'h36; // '6'
            5'd12:   ch = 7'h39; // '9'
            5'd13:   ch = 7'h2B; // '+'
            5'd14:   ch = 7'h2D; // '-'
            5'd15:   ch = 7'h78; // 'x'
            5'd16:   ch = 7'h2F; // '/'
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> sv/mks_if.sv
// Valid/ready channel interfaces for row samples and key reports.
interface mks_row_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_lines;

    modport source (output valid, output row_lines, input ready);
    modport sink   (input valid, input row_lines, output ready);
endinterface

interface mks_key_if;
    logic       valid;
    logic       ready;
    logic [3:0] col_drive;
    logic       key_valid;
    logic [4:0] key_index;
    logic [6:0] legend_char;

    modport source (output valid, output col_drive, output key_valid,
                    output key_index, output legend_char, input ready);
    modport sink   (input valid, input col_drive, input key_valid,
                    input key_index, input legend_char, output ready);
endinterface

>>> sv/matrix_keypad_scanner.sv
// 4x4 matrix keypad scanner: settle, release wait, column scan, key report.
//
// Usage: row_in carries one sampled row nibble per scan tick (active-low rows).
// Each accepted word yields exactly one word on key_out: the column drive
// pattern to apply before the next sample, and, when a press is found, the
// key index (column*4 + row code) and its ASCII legend.
// cfg_we/cfg_data write the settle length in ticks; write only while idle.
// The result word is registered and appears in the cycle after its row word is accepted.
// Throughput: one word per cycle while key_out does not stall; the next-state and
// result logic is a single short combinational pass between the state/result registers.
// Stall: row_in.ready stays high while the result register is empty or being
// taken, so a stalled receiver holds one word and stops further input.
// Reset: scanner enters the pre-release settle wait, column 0, count 0,
// settle length 50, result register empty.
`include "matrix_keypad_scanner_defines.svh"

module matrix_keypad_scanner (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_data,
    mks_row_if.sink       row_in,
    mks_key_if.source     key_out
);
    import mks_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  scan_column_reg, scan_column_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [15:0] settle_ticks_reg;
    logic        out_valid_reg;
    key_word_t   out_word_reg, out_word_next;

    logic        in_accept;
    logic [16:0] tick_inc;
    logic        settle_hit;
    logic [4:0]  key_calc;

    assign row_in.ready = !out_valid_reg || key_out.ready;
    assign in_accept    = row_in.valid && row_in.ready;

    assign tick_inc   = {1'b0, tick_count_reg} + 17'd1;
    assign settle_hit = tick_inc >= {1'b0, settle_ticks_reg};
    assign key_calc   = {1'b0, scan_column_reg, 2'b00} + {2'b00, row_code(row_in.row_lines)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= SETTLE_RESET;
        end
        else if (cfg_we)
        begin
            settle_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SETTLE_PRE;
            scan_column_reg <= 2'd0;
            tick_count_reg  <= 16'd0;
        end
        else if (in_accept)
        begin
            phase_reg       <= phase_next;
            scan_column_reg <= scan_column_next;
            tick_count_reg  <= tick_count_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        scan_column_next = scan_column_reg;
        tick_count_next  = tick_count_reg;
        out_word_next    = '{col_drive: DRIVE_IDLE, key_valid: 1'b0,
                             key_index: 5'd0, legend_char: 7'd0};
        unique case (phase_reg)
            PH_SETTLE_PRE:
            begin
                if (settle_hit)
                begin
                    tick_count_next         = 16'd0;
                    phase_next              = PH_RELEASE;
                    out_word_next.col_drive = DRIVE_ALL;
                end
                else
                begin
                    tick_count_next = tick_inc[15:0];
                end
            end
            PH_RELEASE:
            begin
                if (row_in.row_lines == ROWS_IDLE)
                begin
                    phase_next      = PH_SETTLE_POST;
                    tick_count_next = 16'd0;
                end
                else
                begin
                    out_word_next.col_drive = DRIVE_ALL;
                end
            end
            PH_SETTLE_POST:
            begin
                if (settle_hit)
                begin
                    tick_count_next         = 16'd0;
                    phase_next              = PH_SCAN;
                    scan_column_next        = 2'd0;
                    out_word_next.col_drive = column_drive(2'd0);
                end
                else
                begin
                    tick_count_next = tick_inc[15:0];
                end
            end
            PH_SCAN:
            begin
                if (row_in.row_lines != ROWS_IDLE)
                begin
                    // report the press and restart from the first settle wait
                    out_word_next.key_valid   = 1'b1;
                    out_word_next.key_index   = key_calc;
                    out_word_next.legend_char = legend_of(key_calc);
                    phase_next                = PH_SETTLE_PRE;
                    tick_count_next           = 16'd0;
                    scan_column_next          = 2'd0;
                end
                else
                begin
                    scan_column_next        = scan_column_reg + 2'd1;
                    out_word_next.col_drive = column_drive(scan_column_reg + 2'd1);
                end
            end
            default:
            begin
                phase_next = PH_SETTLE_PRE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (key_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign key_out.valid       = out_valid_reg;
    assign key_out.col_drive   = out_word_reg.col_drive;
    assign key_out.key_valid   = out_word_reg.key_valid;
    assign key_out.key_index   = out_word_reg.key_index;
    assign key_out.legend_char = out_word_reg.legend_char;

    `MKS_ASSERT_NOW(a_col_zero_off_scan, phase_reg != PH_SCAN, scan_column_reg == 2'd0)
    `MKS_ASSERT_NOW(a_count_zero_outside_settle,
        phase_reg == PH_RELEASE || phase_reg == PH_SCAN, tick_count_reg == 16'd0)
    `MKS_ASSERT_NOW(a_report_shape, out_valid_reg && out_word_reg.key_valid,
        out_word_reg.key_index != 5'd0 && out_word_reg.col_drive == DRIVE_IDLE)
    `MKS_ASSERT_NEXT(a_press_restarts,
        in_accept && phase_reg == PH_SCAN && row_in.row_lines != ROWS_IDLE,
        phase_reg == PH_SETTLE_PRE && tick_count_reg == 16'd0 && out_word_reg.key_valid)

endmodule
